[src/pli_pkg.sv]
// Shared types, constants and state codes for the piecewise linear interpolator.
`default_nettype none

package pli_pkg;

  localparam int unsigned MAX_NODES   = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_NODES);
  localparam int unsigned CNT_W       = $clog2(MAX_NODES + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned NODE_W      = 2 * DATA_W;
  localparam int unsigned MD_STEPS    = DATA_W;
  localparam int unsigned MD_STEP_W   = $clog2(MD_STEPS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } pli_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_e                  status;
  } pli_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_DUP_RD,
    S_LD_DUP_CHK,
    S_LD_SH_RD,
    S_LD_SH_CHK,
    S_LD_INS,
    S_Q_RD0,
    S_Q_CHK0,
    S_Q_RDL,
    S_Q_CHKL,
    S_Q_SRD,
    S_Q_SCHK,
    S_Q_PREP,
    S_Q_MUL,
    S_Q_WAIT,
    S_Q_FIN
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

endpackage

`default_nettype wire

[src/piecewise_linear_interpolator.sv]
// Top level of the piecewise linear interpolator: sequencer, node table and arithmetic unit.
`default_nettype none

// The block keeps a table of up to MAX_NODES nodes (x, y) in signed Q16.16,
// sorted by ascending x, and answers queries by linear interpolation between
// the two nodes that bracket the argument. A beat is taken at a clock edge
// where start is high and busy is low. Busy then stays high until the cycle
// in which the single result appears on result_o, marked by done_o, and a new
// beat may already be taken in that same cycle.
// The receiver cannot hold a result off, so it must sample result_o whenever
// done_o is high. A clear, an unused op code, and any load or query that is
// refused at once (invalid or empty table) are answered without raising busy.
// A load scans the n stored nodes for an equal x, with a read state and a
// check state per node, then shifts the s larger nodes up by one in the same
// way and writes the new node; when the table is full it is refused after the
// scan. A query reads the first node and refuses an argument below it, then
// reads the last node and refuses an argument above it or returns its y on a
// match, walks forward to the bracketing segment with a read and a check per
// node, then runs a 32-step multiply and a 32-step divide on one shared adder.
// The node table is a RAM with one write port and one registered read port,
// which is why every scan step needs a read state and a check state. The table
// needs no clearing pass after reset, since only nodes below the stored count
// are ever read.
module piecewise_linear_interpolator import pli_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire pli_in_t item_i,
  output logic         busy,
  output logic         done_o,
  output pli_out_t     result_o
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     inval_q, inval_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic                     done_q, done_d;
  pli_out_t                 res_q, res_d;

  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] y_q, y_d;
  logic signed [DATA_W-1:0] x0_q, x0_d;
  logic signed [DATA_W-1:0] y0_q, y0_d;
  logic signed [DATA_W-1:0] x1_q, x1_d;
  logic signed [DATA_W-1:0] y1_q, y1_d;
  logic [DATA_W:0]          mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [DATA_W-1:0]        dx_q, dx_d;
  logic [DATA_W-1:0]        t_q, t_d;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  node_t                    ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [NODE_W-1:0]        ram_rdata;
  node_t                    rd;

  logic                     md_start;
  logic                     md_done;
  logic [DATA_W-1:0]        md_quot;

  logic [CNT_W-1:0]         idx_m1;
  logic [CNT_W-1:0]         last_idx;
  logic [DATA_W:0]          dy;
  logic [DATA_W:0]          dx_full;
  logic [DATA_W:0]          t_full;
  logic [DATA_W+1:0]        y0_ext;
  logic [DATA_W+1:0]        q_ext;
  logic [DATA_W+1:0]        sum_r;

  assign rd       = node_t'(ram_rdata);
  assign idx_m1   = idx_q - 1'b1;
  assign last_idx = cnt_q - 1'b1;
  assign busy     = (state_q != S_IDLE);

  // Node table, x in the upper half of each word and y in the lower half.
  pli_node_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared serial unit that forms |dy| * (x - x0) / (x1 - x0).
  pli_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mag_i   (mag_q),
    .mult_i  (t_q),
    .div_i   (dx_q),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      inval_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      inval_q <= inval_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    x_q   <= x_d;
    y_q   <= y_d;
    x0_q  <= x0_d;
    y0_q  <= y0_d;
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    dx_q  <= dx_d;
    t_q   <= t_d;
  end

  // Datapath for segment set-up and the final add with saturation.
  assign dy      = {y1_q[DATA_W-1], y1_q} - {y0_q[DATA_W-1], y0_q};
  assign dx_full = {x1_q[DATA_W-1], x1_q} - {x0_q[DATA_W-1], x0_q};
  assign t_full  = {x_q[DATA_W-1], x_q} - {x0_q[DATA_W-1], x0_q};
  assign y0_ext  = {{2{y0_q[DATA_W-1]}}, y0_q};
  assign q_ext   = {2'b00, md_quot};
  assign sum_r   = neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    inval_d   = inval_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    res_d     = res_q;
    x_d       = x_q;
    y_d       = y_q;
    x0_d      = x0_q;
    y0_d      = y0_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    dx_d      = dx_q;
    t_d       = t_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[ADDR_W-1:0];
    ram_wdata = '{x: x_q, y: y_q};
    ram_raddr = '0;
    md_start  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d   = item_i.x_value;
          y_d   = item_i.y_value;
          idx_d = '0;
          res_d = '{result_value: '0, status: ST_OK};
          unique case (item_i.op)
            OP_CLEAR: begin
              cnt_d   = '0;
              inval_d = 1'b0;
              done_d  = 1'b1;
            end
            OP_LOAD: begin
              if (inval_q) begin
                res_d.status = ST_INVALID;
                done_d       = 1'b1;
              end else begin
                state_d = S_LD_DUP_RD;
              end
            end
            OP_QUERY: begin
              if (inval_q) begin
                res_d.status = ST_INVALID;
                done_d       = 1'b1;
              end else if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                state_d = S_Q_RD0;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Load, first pass: look for a node with the same x.
      S_LD_DUP_RD: begin
        if (idx_q == cnt_q) begin
          if (cnt_q >= CNT_W'(MAX_NODES)) begin
            res_d.status = ST_FULL;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else begin
            idx_d   = cnt_q;
            state_d = S_LD_SH_RD;
          end
        end else begin
          ram_raddr = idx_q[ADDR_W-1:0];
          state_d   = S_LD_DUP_CHK;
        end
      end
      S_LD_DUP_CHK: begin
        if (rd.x == x_q) begin
          inval_d      = 1'b1;
          res_d.status = ST_INVALID;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_LD_DUP_RD;
        end
      end

      // Load, second pass: move larger nodes up by one from the top down.
      S_LD_SH_RD: begin
        if (idx_q == '0) begin
          state_d = S_LD_INS;
        end else begin
          ram_raddr = idx_m1[ADDR_W-1:0];
          state_d   = S_LD_SH_CHK;
        end
      end
      S_LD_SH_CHK: begin
        if (rd.x > x_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[ADDR_W-1:0];
          ram_wdata = rd;
          idx_d     = idx_m1;
          state_d   = S_LD_SH_RD;
        end else begin
          state_d = S_LD_INS;
        end
      end
      S_LD_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[ADDR_W-1:0];
        cnt_d     = cnt_q + 1'b1;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      // Query: range checks against the first and last node.
      S_Q_RD0: begin
        ram_raddr = '0;
        state_d   = S_Q_CHK0;
      end
      S_Q_CHK0: begin
        if (x_q < rd.x) begin
          res_d.status = ST_RANGE;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          x0_d    = rd.x;
          y0_d    = rd.y;
          state_d = S_Q_RDL;
        end
      end
      S_Q_RDL: begin
        ram_raddr = last_idx[ADDR_W-1:0];
        state_d   = S_Q_CHKL;
      end
      S_Q_CHKL: begin
        if (x_q > rd.x) begin
          res_d.status = ST_RANGE;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (x_q == rd.x) begin
          res_d.result_value = rd.y;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end else begin
          idx_d   = CNT_W'(1);
          state_d = S_Q_SRD;
        end
      end

      // Query: walk forward to the first node whose x lies above the argument.
      S_Q_SRD: begin
        ram_raddr = idx_q[ADDR_W-1:0];
        state_d   = S_Q_SCHK;
      end
      S_Q_SCHK: begin
        if (x_q < rd.x) begin
          x1_d    = rd.x;
          y1_d    = rd.y;
          state_d = S_Q_PREP;
        end else begin
          x0_d    = rd.x;
          y0_d    = rd.y;
          idx_d   = idx_q + 1'b1;
          state_d = S_Q_SRD;
        end
      end

      // Query: operands for the serial unit, then the final sum.
      S_Q_PREP: begin
        neg_d   = dy[DATA_W];
        mag_d   = dy[DATA_W] ? (~dy + 1'b1) : dy;
        dx_d    = dx_full[DATA_W-1:0];
        t_d     = t_full[DATA_W-1:0];
        state_d = S_Q_MUL;
      end
      S_Q_MUL: begin
        md_start = 1'b1;
        state_d  = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (md_done) begin
          state_d = S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        if (!sum_r[DATA_W+1] && (sum_r[DATA_W] || sum_r[DATA_W-1])) begin
          res_d.result_value = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sum_r[DATA_W+1] && !(sum_r[DATA_W] && sum_r[DATA_W-1])) begin
          res_d.result_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          res_d.result_value = sum_r[DATA_W-1:0];
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  // A result is only shown once the sequencer has come back to rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while the sequencer is still busy");

  // The node count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_NODES))
    else $error("node count beyond table depth");

  // Every refused item carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |-> result_o.result_value == '0)
    else $error("non-zero value on a refused item");

  // An accepted beat either keeps the block busy or finishes at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted beat lost");

  // The serial unit only reports completion while a query waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) md_done |-> state_q == S_Q_WAIT)
    else $error("arithmetic unit finished outside a query");
`endif

endmodule

`default_nettype wire

[src/pli_node_ram.sv]
// Generic single write port, single registered read port RAM for the node table.
`default_nettype none

module pli_node_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/pli_muldiv.sv]
// Bit-serial multiply then divide unit built around one shared adder.
`default_nettype none

module pli_muldiv import pli_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W:0]   mag_i,
  input  wire logic [DATA_W-1:0] mult_i,
  input  wire logic [DATA_W-1:0] div_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quot_o
);

  md_phase_e              phase_q, phase_d;
  logic [MD_STEP_W-1:0]   step_q, step_d;
  logic [DATA_W:0]        hi_q, hi_d;
  logic [DATA_W-1:0]      lo_q, lo_d;
  logic                   done_q, done_d;

  logic [DATA_W+1:0]      op_a, op_b, sum;
  logic                   cin;
  logic [DATA_W:0]        rem_sh;
  logic                   last_step;

  // The partial remainder shifted left by one, taking the next dividend bit.
  assign rem_sh    = {hi_q[DATA_W-1:0], lo_q[DATA_W-1]};
  assign last_step = (step_q == MD_STEP_W'(MD_STEPS - 1));

  // The one adder: accumulate during multiply, trial subtract during divide.
  always_comb begin
    op_a = '0;
    op_b = '0;
    cin  = 1'b0;
    if (phase_q == MD_DIV) begin
      op_a = {1'b0, rem_sh};
      op_b = ~{2'b00, div_i};
      cin  = 1'b1;
    end else begin
      op_a = {1'b0, hi_q};
      op_b = lo_q[0] ? {1'b0, mag_i} : '0;
    end
  end

  assign sum = op_a + op_b + {{(DATA_W+1){1'b0}}, cin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    done_d  = 1'b0;
    unique case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          hi_d    = '0;
          lo_d    = mult_i;
          step_d  = '0;
          phase_d = MD_MUL;
        end
      end
      MD_MUL: begin
        hi_d   = sum[DATA_W+1:1];
        lo_d   = {sum[0], lo_q[DATA_W-1:1]};
        step_d = step_q + 1'b1;
        if (last_step) begin
          step_d  = '0;
          phase_d = MD_DIV;
        end
      end
      MD_DIV: begin
        if (!sum[DATA_W+1]) begin
          hi_d = {1'b0, sum[DATA_W-1:0]};
        end else begin
          hi_d = {1'b0, rem_sh[DATA_W-1:0]};
        end
        lo_d   = {lo_q[DATA_W-2:0], ~sum[DATA_W+1]};
        step_d = step_q + 1'b1;
        if (last_step) begin
          step_d  = '0;
          done_d  = 1'b1;
          phase_d = MD_IDLE;
        end
      end
      default: begin
        phase_d = MD_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

`default_nettype wire
